// File: design/stt_pkg.sv
`default_nettype none
package stt_pkg;

	localparam int OFFSET_BITS_DEF = 32;
	localparam int OUT_OFS_W = 32;
	localparam int KIND_W = 6;
	localparam int ERR_W = 2;
	localparam int MAX_TOK = 3;
	localparam int FIFO_DEPTH = 8;

	typedef enum logic [3:0] {
		M_IDLE    = 4'd0,
		M_COMMENT = 4'd1,
		M_WORD    = 4'd2,
		M_SIGN    = 4'd3,
		M_INT     = 4'd4,
		M_DOT     = 4'd5,
		M_REAL    = 4'd6,
		M_STRING  = 4'd7,
		M_OP      = 4'd8
	} mode_t;

	localparam logic [KIND_W-1:0] K_END    = 6'd0;
	localparam logic [KIND_W-1:0] K_ERROR  = 6'd1;
	localparam logic [KIND_W-1:0] K_IDENT  = 6'd2;
	localparam logic [KIND_W-1:0] K_INT    = 6'd3;
	localparam logic [KIND_W-1:0] K_REAL   = 6'd4;
	localparam logic [KIND_W-1:0] K_BOOL   = 6'd5;
	localparam logic [KIND_W-1:0] K_NULL   = 6'd6;
	localparam logic [KIND_W-1:0] K_STRING = 6'd7;
	localparam logic [KIND_W-1:0] K_LET      = 6'd8;
	localparam logic [KIND_W-1:0] K_IN       = 6'd9;
	localparam logic [KIND_W-1:0] K_IF       = 6'd10;
	localparam logic [KIND_W-1:0] K_THEN     = 6'd11;
	localparam logic [KIND_W-1:0] K_ELSE     = 6'd12;
	localparam logic [KIND_W-1:0] K_PRE      = 6'd13;
	localparam logic [KIND_W-1:0] K_OUT      = 6'd14;
	localparam logic [KIND_W-1:0] K_DEF      = 6'd15;
	localparam logic [KIND_W-1:0] K_SIGNAL   = 6'd16;
	localparam logic [KIND_W-1:0] K_EXTERN   = 6'd17;
	localparam logic [KIND_W-1:0] K_PURE     = 6'd18;
	localparam logic [KIND_W-1:0] K_IMPURE   = 6'd19;
	localparam logic [KIND_W-1:0] K_FUNCTION = 6'd20;
	localparam logic [KIND_W-1:0] K_STRUCT   = 6'd21;
	localparam logic [KIND_W-1:0] K_LAND     = 6'd22;
	localparam logic [KIND_W-1:0] K_LOR      = 6'd23;
	localparam logic [KIND_W-1:0] K_ASSIGN   = 6'd24;
	localparam logic [KIND_W-1:0] K_LE       = 6'd25;
	localparam logic [KIND_W-1:0] K_GE       = 6'd26;
	localparam logic [KIND_W-1:0] K_NE       = 6'd27;
	localparam logic [KIND_W-1:0] K_SHL      = 6'd28;
	localparam logic [KIND_W-1:0] K_SHR      = 6'd29;
	localparam logic [KIND_W-1:0] K_ARROW    = 6'd30;
	localparam logic [KIND_W-1:0] K_AMP      = 6'd31;
	localparam logic [KIND_W-1:0] K_BAR      = 6'd32;
	localparam logic [KIND_W-1:0] K_EQ       = 6'd33;
	localparam logic [KIND_W-1:0] K_LT       = 6'd34;
	localparam logic [KIND_W-1:0] K_GT       = 6'd35;
	localparam logic [KIND_W-1:0] K_PLUS     = 6'd36;
	localparam logic [KIND_W-1:0] K_MINUS    = 6'd37;
	localparam logic [KIND_W-1:0] K_STAR     = 6'd38;
	localparam logic [KIND_W-1:0] K_SLASH    = 6'd39;
	localparam logic [KIND_W-1:0] K_PCT      = 6'd40;
	localparam logic [KIND_W-1:0] K_QUEST    = 6'd41;
	localparam logic [KIND_W-1:0] K_LPAREN   = 6'd42;
	localparam logic [KIND_W-1:0] K_RPAREN   = 6'd43;
	localparam logic [KIND_W-1:0] K_LBRACE   = 6'd44;
	localparam logic [KIND_W-1:0] K_RBRACE   = 6'd45;
	localparam logic [KIND_W-1:0] K_COMMA    = 6'd46;
	localparam logic [KIND_W-1:0] K_COLON    = 6'd47;
	// no operator matched
	localparam logic [KIND_W-1:0] K_NO_OP    = 6'd0;

	localparam logic [ERR_W-1:0] E_NONE    = 2'd0;
	localparam logic [ERR_W-1:0] E_RANGE   = 2'd1;
	localparam logic [ERR_W-1:0] E_QUOTE   = 2'd2;
	localparam logic [ERR_W-1:0] E_UNKNOWN = 2'd3;

	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_END  = 1'b1;

	typedef struct packed {
		logic [KIND_W-1:0]    kind;
		logic [OUT_OFS_W-1:0] start_ofs;
		logic [OUT_OFS_W-1:0] end_ofs;
		logic signed [63:0]   ival;
		logic                 bval;
		logic [ERR_W-1:0]     err;
		logic                 last;
	} token_t;

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_eol(input logic [7:0] c);
		return c == 8'h0d || c == 8'h0a;
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return c == " " || c == 8'h09 || is_eol(c);
	endfunction

	function automatic logic [KIND_W-1:0] single_op(input logic [7:0] c);
		logic [KIND_W-1:0] k;
		unique case (c)
			"&": k = K_AMP;
			"|": k = K_BAR;
			"=": k = K_EQ;
			"<": k = K_LT;
			">": k = K_GT;
			"+": k = K_PLUS;
			"-": k = K_MINUS;
			"*": k = K_STAR;
			"/": k = K_SLASH;
			"%": k = K_PCT;
			"?": k = K_QUEST;
			"(": k = K_LPAREN;
			")": k = K_RPAREN;
			"{": k = K_LBRACE;
			"}": k = K_RBRACE;
			",": k = K_COMMA;
			":": k = K_COLON;
			default: k = K_NO_OP;
		endcase
		return k;
	endfunction

	function automatic logic [KIND_W-1:0] pair_op(input logic [7:0] a, input logic [7:0] b);
		logic [KIND_W-1:0] k;
		priority if (a == "&" && b == "&") k = K_LAND;
		else if (a == "|" && b == "|") k = K_LOR;
		else if (a == ":" && b == "=") k = K_ASSIGN;
		else if (a == "<" && b == "=") k = K_LE;
		else if (a == ">" && b == "=") k = K_GE;
		else if (a == "/" && b == "=") k = K_NE;
		else if (a == "<" && b == "<") k = K_SHL;
		else if (a == ">" && b == ">") k = K_SHR;
		else k = K_NO_OP;
		return k;
	endfunction

	// buffer byte 0 in bits [7:0]; unused bytes are zero
	function automatic logic [KIND_W-1:0] word_kind(input logic [63:0] w, input logic [3:0] n);
		logic [KIND_W-1:0] k;
		k = K_IDENT;
		unique case (n)
			4'd2: begin
				if (w == 64'h6e69) k = K_IN;
				else if (w == 64'h6669) k = K_IF;
			end
			4'd3: begin
				if (w == 64'h74656c) k = K_LET;
				else if (w == 64'h657270) k = K_PRE;
				else if (w == 64'h74756f) k = K_OUT;
				else if (w == 64'h666564) k = K_DEF;
			end
			4'd4: begin
				if (w == 64'h65757274) k = K_BOOL;
				else if (w == 64'h6c6c756e) k = K_NULL;
				else if (w == 64'h6e656874) k = K_THEN;
				else if (w == 64'h65736c65) k = K_ELSE;
				else if (w == 64'h65727570) k = K_PURE;
			end
			4'd5: begin
				if (w == 64'h65736c6166) k = K_BOOL;
			end
			4'd6: begin
				if (w == 64'h6c616e676973) k = K_SIGNAL;
				else if (w == 64'h6e7265747865) k = K_EXTERN;
				else if (w == 64'h657275706d69) k = K_IMPURE;
				else if (w == 64'h746375727473) k = K_STRUCT;
			end
			4'd8: begin
				if (w == 64'h6e6f6974636e7566) k = K_FUNCTION;
			end
			default: k = K_IDENT;
		endcase
		return k;
	endfunction

endpackage
`default_nettype wire

// File: design/stt_fifo.sv
`default_nettype none
module stt_fifo #(
	parameter int DEPTH = stt_pkg::FIFO_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [1:0]        push_n,
	input  stt_pkg::token_t        push_tok [stt_pkg::MAX_TOK],
	output logic                   room,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output stt_pkg::token_t        out_tok
);
	localparam int AW = $clog2(DEPTH);

	stt_pkg::token_t mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;
	logic          pop;
	logic [AW:0]   n_ext;

	assign pop       = out_valid && out_ready;
	assign out_valid = cnt_q != '0;
	assign out_tok   = mem_q[rd_q];
	assign n_ext     = {{(AW-1){1'b0}}, push_n};
	// room for a full run of tokens regardless of pop this cycle
	assign room      = cnt_q <= (AW+1)'(DEPTH - stt_pkg::MAX_TOK);

	always_ff @(posedge clk) begin
		for (int i = 0; i < stt_pkg::MAX_TOK; i++) begin
			if (i < int'(push_n)) mem_q[wr_q + AW'(i)] <= push_tok[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + n_ext[AW-1:0];
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + n_ext - (AW+1)'(pop);
		end
	end
endmodule
`default_nettype wire

// File: design/source_text_tokenizer_core.sv
// A token enters the output queue at the edge that accepts its deciding byte.
// Throughput: one byte or end command per cycle; a flush of up to three tokens
// drains from an eight-entry output queue, one token per cycle while out_ready
// is high. in_ready drops while the queue could not take three more tokens.
// Reset (arst_n low, asynchronous): idle mode, offset zero, queue empty.
`default_nettype none
module source_text_tokenizer_core #(
	parameter int OFFSET_BITS = stt_pkg::OFFSET_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        command,
	input  wire logic [7:0]  text_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [5:0]       token_kind,
	output logic [31:0]      start_offset,
	output logic [31:0]      end_offset,
	output logic signed [63:0] int_value,
	output logic             bool_value,
	output logic [1:0]       error_code,
	output logic             last_of_run
);
	localparam logic [OFFSET_BITS-1:0] PMAX = '1;
	localparam logic [63:0] LIM_POS = 64'h7fff_ffff_ffff_ffff;

	stt_pkg::mode_t mode_q, mode_d;
	logic [OFFSET_BITS-1:0] pos_q, tstart_q, dotpos_q;
	logic [OFFSET_BITS-1:0] tstart_d, dotpos_d, nx;
	logic [63:0] wbuf_q, wbuf_d, acc_q, acc_d;
	logic [3:0]  wlen_q, wlen_d;
	logic        dot_ok_q, dot_ok_d, neg_q, neg_d, ovf_q, ovf_d;
	logic [7:0]  held_q, held_d;

	stt_pkg::token_t tok [stt_pkg::MAX_TOK];
	logic [1:0] n;
	logic       acc_in;
	logic       room;

	assign in_ready = room;
	assign acc_in   = in_valid && in_ready;
	assign nx       = (pos_q == PMAX) ? pos_q : pos_q + 1'b1;

	function automatic logic [31:0] o32(input logic [OFFSET_BITS-1:0] v);
		logic [63:0] w;
		w = 64'(v);
		return w[31:0];
	endfunction

	function automatic stt_pkg::token_t mk(input logic [5:0] k,
		input logic [OFFSET_BITS-1:0] s, input logic [OFFSET_BITS-1:0] e,
		input logic [63:0] iv, input logic bv, input logic [1:0] er);
		stt_pkg::token_t t;
		t.kind = k;
		t.start_ofs = o32(s);
		t.end_ofs = o32(e);
		t.ival = iv;
		t.bval = bv;
		t.err = er;
		t.last = 1'b0;
		return t;
	endfunction

	logic [63:0] digit_acc;
	logic        digit_ovf;
	logic [3:0]  dval;
	logic [63:0] lim_x;
	logic [67:0] prod;
	logic        neg_use;

	// one multiply-by-ten with range check for digits after a sign or a digit
	always_comb begin
		logic [63:0] base;
		logic        ovf_in;
		dval    = text_byte[3:0];
		base    = (mode_q == stt_pkg::M_INT) ? acc_q : 64'd0;
		ovf_in  = (mode_q == stt_pkg::M_INT) ? ovf_q : 1'b0;
		neg_use = (mode_q == stt_pkg::M_INT) ? neg_q : (mode_q == stt_pkg::M_SIGN &&
			held_q == "-");
		lim_x   = neg_use ? (LIM_POS + 64'd1) : LIM_POS;
		prod    = {base, 3'b000} + {2'b00, base, 1'b0} + 68'(dval);
		digit_ovf = ovf_in || (prod > 68'(lim_x));
		digit_acc = digit_ovf ? base : prod[63:0];
	end

	logic [63:0] int_v;
	assign int_v = neg_q ? (64'd0 - acc_q) : acc_q;

	always_comb begin
		stt_pkg::token_t pend [2];
		logic [1:0] np;
		logic       to_idle;
		logic [5:0] wk;
		logic [5:0] pk;

		mode_d = mode_q; tstart_d = tstart_q; dotpos_d = dotpos_q;
		wbuf_d = wbuf_q; wlen_d = wlen_q; dot_ok_d = dot_ok_q;
		acc_d = acc_q; neg_d = neg_q; ovf_d = ovf_q; held_d = held_q;
		for (int i = 0; i < stt_pkg::MAX_TOK; i++)
			tok[i] = mk(stt_pkg::K_END, '0, '0, 64'd0, 1'b0, stt_pkg::E_NONE);
		pend[0] = tok[0];
		pend[1] = tok[0];
		np = 2'd0;
		to_idle = 1'b0;
		wk = stt_pkg::word_kind(wbuf_q, wlen_q);
		pk = stt_pkg::pair_op(held_q, text_byte);

		// pending tokens end at the current offset, an int before a dot at the dot
		unique case (mode_q)
			stt_pkg::M_WORD: begin
				pend[0] = mk(wk, tstart_q, pos_q, 64'd0,
					wk == stt_pkg::K_BOOL && wlen_q == 4'd4, stt_pkg::E_NONE);
				np = 2'd1;
			end
			stt_pkg::M_SIGN, stt_pkg::M_OP: begin
				pend[0] = mk(stt_pkg::single_op(held_q), tstart_q, pos_q, 64'd0, 1'b0,
					stt_pkg::E_NONE);
				np = 2'd1;
			end
			stt_pkg::M_INT: begin
				pend[0] = ovf_q ? mk(stt_pkg::K_ERROR, tstart_q, pos_q, 64'd0, 1'b0,
					stt_pkg::E_RANGE) : mk(stt_pkg::K_INT, tstart_q, pos_q, int_v, 1'b0,
					stt_pkg::E_NONE);
				np = 2'd1;
			end
			stt_pkg::M_DOT: begin
				pend[0] = ovf_q ? mk(stt_pkg::K_ERROR, tstart_q, dotpos_q, 64'd0, 1'b0,
					stt_pkg::E_RANGE) : mk(stt_pkg::K_INT, tstart_q, dotpos_q, int_v, 1'b0,
					stt_pkg::E_NONE);
				pend[1] = mk(stt_pkg::K_ERROR, dotpos_q, pos_q, 64'd0, 1'b0,
					stt_pkg::E_UNKNOWN);
				np = 2'd2;
			end
			stt_pkg::M_REAL: begin
				pend[0] = mk(stt_pkg::K_REAL, tstart_q, pos_q, 64'd0, 1'b0,
					stt_pkg::E_NONE);
				np = 2'd1;
			end
			stt_pkg::M_STRING: begin
				pend[0] = mk(stt_pkg::K_ERROR, tstart_q, pos_q, 64'd0, 1'b0,
					stt_pkg::E_QUOTE);
				np = 2'd1;
			end
			default: np = 2'd0;
		endcase

		n = 2'd0;
		if (command == stt_pkg::CMD_END) begin
			tok[0] = pend[0];
			tok[1] = pend[1];
			tok[np] = mk(stt_pkg::K_END, pos_q, pos_q, 64'd0, 1'b0, stt_pkg::E_NONE);
			n = np + 2'd1;
			mode_d = stt_pkg::M_IDLE;
		end else begin
			unique case (mode_q)
				stt_pkg::M_COMMENT: if (stt_pkg::is_eol(text_byte)) mode_d = stt_pkg::M_IDLE;
				stt_pkg::M_WORD: begin
					if (stt_pkg::is_letter(text_byte) || stt_pkg::is_digit(text_byte) ||
						text_byte == "_" || (text_byte == "." && dot_ok_q)) begin
						if (wlen_q < 4'd8) wbuf_d[wlen_q[2:0]*8 +: 8] = text_byte;
						if (wlen_q < 4'd9) wlen_d = wlen_q + 4'd1;
						dot_ok_d = text_byte != ".";
					end else begin
						tok[0] = pend[0]; n = 2'd1; to_idle = 1'b1;
					end
				end
				stt_pkg::M_SIGN: begin
					if (stt_pkg::is_digit(text_byte)) begin
						mode_d = stt_pkg::M_INT; acc_d = digit_acc; ovf_d = digit_ovf;
						neg_d = neg_use;
					end else if (held_q == "-" && text_byte == ">") begin
						tok[0] = mk(stt_pkg::K_ARROW, tstart_q, nx, 64'd0, 1'b0,
							stt_pkg::E_NONE);
						n = 2'd1; mode_d = stt_pkg::M_IDLE;
					end else begin
						tok[0] = pend[0]; n = 2'd1; to_idle = 1'b1;
					end
				end
				stt_pkg::M_INT: begin
					if (stt_pkg::is_digit(text_byte)) begin
						acc_d = digit_acc; ovf_d = digit_ovf;
					end else if (text_byte == ".") begin
						mode_d = stt_pkg::M_DOT; dotpos_d = pos_q;
					end else begin
						tok[0] = pend[0]; n = 2'd1; to_idle = 1'b1;
					end
				end
				stt_pkg::M_DOT: begin
					if (stt_pkg::is_digit(text_byte)) mode_d = stt_pkg::M_REAL;
					else begin
						tok[0] = pend[0]; tok[1] = pend[1]; n = 2'd2; to_idle = 1'b1;
					end
				end
				stt_pkg::M_REAL: begin
					if (!stt_pkg::is_digit(text_byte)) begin
						tok[0] = pend[0]; n = 2'd1; to_idle = 1'b1;
					end
				end
				stt_pkg::M_STRING: begin
					if (text_byte == "\"") begin
						tok[0] = mk(stt_pkg::K_STRING, tstart_q, nx, 64'd0, 1'b0,
							stt_pkg::E_NONE);
						n = 2'd1; mode_d = stt_pkg::M_IDLE;
					end else if (stt_pkg::is_eol(text_byte)) begin
						tok[0] = pend[0]; n = 2'd1; mode_d = stt_pkg::M_IDLE;
					end
				end
				stt_pkg::M_OP: begin
					if (pk != 6'd0) begin
						tok[0] = mk(pk, tstart_q, nx, 64'd0, 1'b0, stt_pkg::E_NONE);
						n = 2'd1; mode_d = stt_pkg::M_IDLE;
					end else begin
						tok[0] = pend[0]; n = 2'd1; to_idle = 1'b1;
					end
				end
				default: to_idle = 1'b1;
			endcase

			if (to_idle) begin
				mode_d = stt_pkg::M_IDLE;
				priority if (stt_pkg::is_blank(text_byte)) begin
				end else if (text_byte == "#") begin
					mode_d = stt_pkg::M_COMMENT;
				end else if (stt_pkg::is_letter(text_byte) || text_byte == "_") begin
					mode_d = stt_pkg::M_WORD; tstart_d = pos_q;
					wbuf_d = {56'd0, text_byte}; wlen_d = 4'd1; dot_ok_d = 1'b1;
				end else begin
					tstart_d = pos_q;
					priority if (stt_pkg::is_digit(text_byte)) begin
						mode_d = stt_pkg::M_INT; neg_d = 1'b0;
						acc_d = 64'(dval); ovf_d = 1'b0;
					end else if (text_byte == "+" || text_byte == "-") begin
						mode_d = stt_pkg::M_SIGN; held_d = text_byte;
					end else if (text_byte == "\"") begin
						mode_d = stt_pkg::M_STRING;
					end else if (text_byte == "&" || text_byte == "|" || text_byte == ":" ||
						text_byte == "<" || text_byte == ">" || text_byte == "/") begin
						mode_d = stt_pkg::M_OP; held_d = text_byte;
					end else begin
						tok[n] = (stt_pkg::single_op(text_byte) != 6'd0) ?
							mk(stt_pkg::single_op(text_byte), pos_q, nx, 64'd0, 1'b0,
							stt_pkg::E_NONE) :
							mk(stt_pkg::K_ERROR, pos_q, nx, 64'd0, 1'b0, stt_pkg::E_UNKNOWN);
						n = n + 2'd1;
					end
				end
			end
		end
		if (n != 2'd0) tok[n - 2'd1].last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= stt_pkg::M_IDLE;
			pos_q <= '0; tstart_q <= '0; dotpos_q <= '0;
			wbuf_q <= '0; wlen_q <= '0; dot_ok_q <= 1'b1;
			acc_q <= '0; neg_q <= 1'b0; ovf_q <= 1'b0; held_q <= '0;
		end else if (acc_in) begin
			mode_q <= mode_d; tstart_q <= tstart_d; dotpos_q <= dotpos_d;
			wbuf_q <= wbuf_d; wlen_q <= wlen_d; dot_ok_q <= dot_ok_d;
			acc_q <= acc_d; neg_q <= neg_d; ovf_q <= ovf_d; held_q <= held_d;
			if (command == stt_pkg::CMD_BYTE) pos_q <= nx;
		end
	end

	stt_pkg::token_t head;

	stt_fifo #(.DEPTH(stt_pkg::FIFO_DEPTH)) u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push_n(acc_in ? n : 2'd0), .push_tok(tok), .room(room),
		.out_valid(out_valid), .out_ready(out_ready), .out_tok(head)
	);

	assign token_kind   = head.kind;
	assign start_offset = head.start_ofs;
	assign end_offset   = head.end_ofs;
	assign int_value    = head.ival;
	assign bool_value   = head.bval;
	assign error_code   = head.err;
	assign last_of_run  = head.last;
endmodule
`default_nettype wire

// File: design/stt_checker.sv
`default_nettype none
module stt_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [5:0]  token_kind,
	input wire logic [31:0] start_offset,
	input wire logic [31:0] end_offset,
	input wire logic signed [63:0] int_value,
	input wire logic [1:0]  error_code,
	input wire logic        last_of_run
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(token_kind))
		else $error("output transaction dropped while stalled");
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind == stt_pkg::K_END |-> last_of_run &&
		start_offset == end_offset)
		else $error("end token malformed");
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind != stt_pkg::K_ERROR |-> error_code == stt_pkg::E_NONE)
		else $error("error code on non-error token");
	a_ival: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind != stt_pkg::K_INT |-> int_value == 64'sd0)
		else $error("value on non-integer token");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |-> out_valid)
		else $error("input stalled with output queue empty");
endmodule

bind source_text_tokenizer_core stt_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .token_kind(token_kind),
	.start_offset(start_offset), .end_offset(end_offset), .int_value(int_value),
	.error_code(error_code), .last_of_run(last_of_run)
);
`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

	typedef struct packed {
		logic        cmd;
		logic [7:0]  ch;
	} src_item_t;

	typedef struct {
		logic [5:0]         kind;
		logic [31:0]        s;
		logic [31:0]        e;
		logic signed [63:0] ival;
		logic               bval;
		logic [1:0]         err;
		logic               last;
	} tok_exp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic command = 1'b0;
	logic [7:0] text_byte = 8'd0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [5:0] token_kind;
	logic [31:0] start_offset, end_offset;
	logic signed [63:0] int_value;
	logic bool_value;
	logic [1:0] error_code;
	logic last_of_run;

	source_text_tokenizer_core uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .text_byte(text_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.token_kind(token_kind), .start_offset(start_offset), .end_offset(end_offset),
		.int_value(int_value), .bool_value(bool_value), .error_code(error_code),
		.last_of_run(last_of_run)
	);

	src_item_t pending_src[$];
	tok_exp_t  expected_tokens[$];
	int  errors = 0;
	bit  stim_done = 1'b0;
	bit  in_noidle = 1'b0, out_noidle = 1'b0;
	int  hold_cycles = 0;
	bit  src_pause = 1'b0;

	// tokenizer state
	stt_pkg::mode_t sc_mode = stt_pkg::M_IDLE;
	logic [31:0] sc_pos = 0, sc_start = 0, sc_dotpos = 0;
	logic [7:0]  sc_word[8];
	logic [3:0]  sc_wlen = 0;
	bit          sc_dot_ok = 1;
	logic [63:0] sc_acc = 0;
	bit          sc_neg = 0, sc_ovf = 0;
	logic [7:0]  sc_held = 0;
	tok_exp_t    run_toks[$];

	initial forever #5 clk = ~clk;

	function automatic bit c_digit(logic [7:0] c); return c >= "0" && c <= "9"; endfunction
	function automatic bit c_letter(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction
	function automatic bit c_eol(logic [7:0] c); return c == 8'h0d || c == 8'h0a; endfunction
	function automatic bit c_blank(logic [7:0] c);
		return c == " " || c == 8'h09 || c_eol(c);
	endfunction

	function automatic logic [5:0] op1(logic [7:0] c);
		case (c)
			"&": return stt_pkg::K_AMP;    "|": return stt_pkg::K_BAR;
			"=": return stt_pkg::K_EQ;     "<": return stt_pkg::K_LT;
			">": return stt_pkg::K_GT;     "+": return stt_pkg::K_PLUS;
			"-": return stt_pkg::K_MINUS;  "*": return stt_pkg::K_STAR;
			"/": return stt_pkg::K_SLASH;  "%": return stt_pkg::K_PCT;
			"?": return stt_pkg::K_QUEST;  "(": return stt_pkg::K_LPAREN;
			")": return stt_pkg::K_RPAREN; "{": return stt_pkg::K_LBRACE;
			"}": return stt_pkg::K_RBRACE; ",": return stt_pkg::K_COMMA;
			":": return stt_pkg::K_COLON;
			default: return stt_pkg::K_NO_OP;
		endcase
	endfunction

	function automatic logic [5:0] op2(logic [7:0] a, logic [7:0] b);
		string p;
		p = {string'(a), string'(b)};
		case (p)
			"&&": return stt_pkg::K_LAND;   "||": return stt_pkg::K_LOR;
			":=": return stt_pkg::K_ASSIGN; "<=": return stt_pkg::K_LE;
			">=": return stt_pkg::K_GE;     "/=": return stt_pkg::K_NE;
			"<<": return stt_pkg::K_SHL;    ">>": return stt_pkg::K_SHR;
			default: return stt_pkg::K_NO_OP;
		endcase
	endfunction

	task automatic push_tok(logic [5:0] k, logic [31:0] s, logic [31:0] e,
			logic [63:0] v, bit b, logic [1:0] er);
		tok_exp_t t;
		t.kind = k; t.s = s; t.e = e; t.ival = v; t.bval = b; t.err = er; t.last = 0;
		if (run_toks.size() < stt_pkg::MAX_TOK) run_toks.push_back(t);
	endtask

	task automatic word_tok(logic [31:0] e);
		string w;
		logic [5:0] k;
		bit b;
		w = "";
		b = 0;
		k = stt_pkg::K_IDENT;
		if (sc_wlen <= 8)
			for (int i = 0; i < sc_wlen; i++) w = {w, string'(sc_word[i])};
		case (w)
			"true": begin k = stt_pkg::K_BOOL; b = 1; end
			"false": k = stt_pkg::K_BOOL;
			"null": k = stt_pkg::K_NULL;
			"let": k = stt_pkg::K_LET; "in": k = stt_pkg::K_IN; "if": k = stt_pkg::K_IF;
			"then": k = stt_pkg::K_THEN; "else": k = stt_pkg::K_ELSE;
			"pre": k = stt_pkg::K_PRE; "out": k = stt_pkg::K_OUT; "def": k = stt_pkg::K_DEF;
			"signal": k = stt_pkg::K_SIGNAL; "extern": k = stt_pkg::K_EXTERN;
			"pure": k = stt_pkg::K_PURE; "impure": k = stt_pkg::K_IMPURE;
			"function": k = stt_pkg::K_FUNCTION; "struct": k = stt_pkg::K_STRUCT;
			default: k = stt_pkg::K_IDENT;
		endcase
		push_tok(k, sc_start, e, 0, b, stt_pkg::E_NONE);
	endtask

	task automatic int_tok(logic [31:0] e);
		if (sc_ovf) push_tok(stt_pkg::K_ERROR, sc_start, e, 0, 0, stt_pkg::E_RANGE);
		else push_tok(stt_pkg::K_INT, sc_start, e, sc_neg ? -sc_acc : sc_acc, 0,
			stt_pkg::E_NONE);
	endtask

	task automatic add_dig(logic [7:0] c);
		logic [63:0] d, lim;
		d = c - "0";
		lim = sc_neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
		if (sc_ovf) return;
		if (sc_acc > (lim - d) / 10) sc_ovf = 1;
		else sc_acc = sc_acc * 10 + d;
	endtask

	task automatic idle_byte(logic [7:0] c, logic [31:0] p, logic [31:0] nx);
		sc_mode = stt_pkg::M_IDLE;
		if (c_blank(c)) return;
		if (c == "#") begin sc_mode = stt_pkg::M_COMMENT; return; end
		if (c_letter(c) || c == "_") begin
			sc_mode = stt_pkg::M_WORD; sc_start = p;
			foreach (sc_word[i]) sc_word[i] = 0;
			sc_word[0] = c; sc_wlen = 1; sc_dot_ok = 1;
			return;
		end
		sc_start = p;
		if (c_digit(c)) begin
			sc_mode = stt_pkg::M_INT; sc_acc = 0; sc_neg = 0; sc_ovf = 0; add_dig(c);
		end else if (c == "+" || c == "-") begin
			sc_mode = stt_pkg::M_SIGN; sc_held = c;
		end else if (c == "\"") begin
			sc_mode = stt_pkg::M_STRING;
		end else if (c == "&" || c == "|" || c == ":" || c == "<" || c == ">" || c == "/") begin
			sc_mode = stt_pkg::M_OP; sc_held = c;
		end else if (op1(c) != stt_pkg::K_NO_OP) push_tok(op1(c), p, nx, 0, 0, stt_pkg::E_NONE);
		else push_tok(stt_pkg::K_ERROR, p, nx, 0, 0, stt_pkg::E_UNKNOWN);
	endtask

	task automatic predict_tokens(src_item_t it);
		logic [31:0] p, nx;
		logic [7:0] c;
		logic [5:0] k;
		p = sc_pos;
		nx = (p == 32'hffff_ffff) ? p : p + 1;
		c = it.ch;
		run_toks.delete();
		if (it.cmd == stt_pkg::CMD_END) begin
			case (sc_mode)
				stt_pkg::M_WORD: word_tok(p);
				stt_pkg::M_SIGN, stt_pkg::M_OP:
					push_tok(op1(sc_held), sc_start, p, 0, 0, stt_pkg::E_NONE);
				stt_pkg::M_INT: int_tok(p);
				stt_pkg::M_DOT: begin
					int_tok(sc_dotpos);
					push_tok(stt_pkg::K_ERROR, sc_dotpos, p, 0, 0, stt_pkg::E_UNKNOWN);
				end
				stt_pkg::M_REAL: push_tok(stt_pkg::K_REAL, sc_start, p, 0, 0, stt_pkg::E_NONE);
				stt_pkg::M_STRING:
					push_tok(stt_pkg::K_ERROR, sc_start, p, 0, 0, stt_pkg::E_QUOTE);
				default: ;
			endcase
			sc_mode = stt_pkg::M_IDLE;
			push_tok(stt_pkg::K_END, p, p, 0, 0, stt_pkg::E_NONE);
		end else begin
			case (sc_mode)
				stt_pkg::M_COMMENT: if (c_eol(c)) sc_mode = stt_pkg::M_IDLE;
				stt_pkg::M_WORD:
					if (c_letter(c) || c_digit(c) || c == "_" || (c == "." && sc_dot_ok)) begin
						if (sc_wlen < 8) sc_word[sc_wlen] = c;
						if (sc_wlen < 9) sc_wlen++;
						sc_dot_ok = (c != ".");
					end else begin
						word_tok(p); idle_byte(c, p, nx);
					end
				stt_pkg::M_SIGN:
					if (c_digit(c)) begin
						sc_mode = stt_pkg::M_INT; sc_acc = 0; sc_neg = (sc_held == "-");
						sc_ovf = 0;
						add_dig(c);
					end else if (sc_held == "-" && c == ">") begin
						push_tok(stt_pkg::K_ARROW, sc_start, nx, 0, 0, stt_pkg::E_NONE);
						sc_mode = stt_pkg::M_IDLE;
					end else begin
						push_tok(op1(sc_held), sc_start, p, 0, 0, stt_pkg::E_NONE);
						idle_byte(c, p, nx);
					end
				stt_pkg::M_INT:
					if (c_digit(c)) add_dig(c);
					else if (c == ".") begin sc_mode = stt_pkg::M_DOT; sc_dotpos = p; end
					else begin int_tok(p); idle_byte(c, p, nx); end
				stt_pkg::M_DOT:
					if (c_digit(c)) sc_mode = stt_pkg::M_REAL;
					else begin
						int_tok(sc_dotpos);
						push_tok(stt_pkg::K_ERROR, sc_dotpos, p, 0, 0, stt_pkg::E_UNKNOWN);
						idle_byte(c, p, nx);
					end
				stt_pkg::M_REAL:
					if (!c_digit(c)) begin
						push_tok(stt_pkg::K_REAL, sc_start, p, 0, 0, stt_pkg::E_NONE);
						idle_byte(c, p, nx);
					end
				stt_pkg::M_STRING:
					if (c == "\"") begin
						push_tok(stt_pkg::K_STRING, sc_start, nx, 0, 0, stt_pkg::E_NONE);
						sc_mode = stt_pkg::M_IDLE;
					end else if (c_eol(c)) begin
						push_tok(stt_pkg::K_ERROR, sc_start, p, 0, 0, stt_pkg::E_QUOTE);
						sc_mode = stt_pkg::M_IDLE;
					end
				stt_pkg::M_OP: begin
					k = op2(sc_held, c);
					if (k != stt_pkg::K_NO_OP) begin
						push_tok(k, sc_start, nx, 0, 0, stt_pkg::E_NONE);
						sc_mode = stt_pkg::M_IDLE;
					end else begin
						push_tok(op1(sc_held), sc_start, p, 0, 0, stt_pkg::E_NONE);
						idle_byte(c, p, nx);
					end
				end
				default: idle_byte(c, p, nx);
			endcase
			sc_pos = nx;
		end
		if (run_toks.size() > 0) run_toks[run_toks.size() - 1].last = 1;
		foreach (run_toks[i]) expected_tokens.push_back(run_toks[i]);
	endtask

	// driver
	always @(posedge clk) begin
		src_item_t nxt;
		if (arst_n) begin
			if (in_valid && in_ready) predict_tokens('{command, text_byte});
			if (!in_valid || in_ready) begin
				if (pending_src.size() > 0 && !src_pause &&
						(in_noidle || $urandom_range(99) >= 12)) begin
					nxt = pending_src.pop_front();
					in_valid <= 1'b1;
					command <= nxt.cmd;
					text_byte <= nxt.ch;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		tok_exp_t x;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_tokens.size() == 0) begin
					errors++;
					$display("%0t: unexpected token kind %0d", $time, token_kind);
				end else begin
					x = expected_tokens.pop_front();
					if ({x.kind, x.s, x.e, x.ival, x.bval, x.err, x.last} !==
							{token_kind, start_offset, end_offset, int_value, bool_value,
							error_code, last_of_run}) begin
						errors++;
						$display("%0t: mismatch exp k=%0d s=%0d e=%0d v=%0d b=%0d er=%0d l=%0d",
							$time, x.kind, x.s, x.e, x.ival, x.bval, x.err, x.last);
						$display("%0t:          got k=%0d s=%0d e=%0d v=%0d b=%0d er=%0d l=%0d",
							$time, token_kind, start_offset, end_offset, int_value,
							bool_value, error_code, last_of_run);
					end
				end
			end
			if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= out_noidle || $urandom_range(99) >= 12;
			end
		end
	end

	task automatic add_text(string s);
		for (int i = 0; i < s.len(); i++) pending_src.push_back('{stt_pkg::CMD_BYTE, s[i]});
	endtask

	task automatic add_end();
		pending_src.push_back('{stt_pkg::CMD_END, 8'd0});
	endtask

	task automatic wait_drained();
		while (pending_src.size() > 0 || in_valid || expected_tokens.size() > 0) @(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	function automatic string rand_fragment();
		string pool[] = '{"let", "in", "if", "then", "else", "pre", "out", "def", "signal",
			"extern", "pure", "impure", "function", "struct", "true", "false", "null",
			"a.b.c", "x_1", "longidentifier", "a..b", "42", "-17", "+8", "3.25", "7.",
			"9223372036854775808", "-9223372036854775808", "99999999999999999999",
			"\"str\"", "\"open\n", "&&", "||", ":=", "<=", ">=", "/=", "<<", ">>", "->",
			"&", "|", "=", "<", ">", "+", "-", "*", "/", "%", "?", "(", ")", "{", "}",
			",", ":", "# note\n", " ", "\t", "\r", "\n", "@", "-x", "+ "};
		return pool[$urandom_range(pool.size() - 1)];
	endfunction

	initial begin
		string frag;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		// directed
		add_text("let x:=-9223372036854775808+9223372036854775807 ");
		add_text("y.z.w1 true false null \"s\" 1.5 2.x 3");
		add_end();
		add_text("\"unterm");
		add_end();
		add_text("&&||<<>>->/=@~# c\n");
		add_text({8'hff, 8'h00, 8'h80, 8'h7f, "9223372036854775808 +5"});
		add_end();
		wait_drained();
		// receiver holds off while sender keeps offering
		in_noidle = 1;
		hold_cycles = 60;
		add_text("a+b+c+d+e+f+g+h+i+j+k+l+m+n");
		wait_drained();
		in_noidle = 0;
		// random: mostly well-formed text, some raw bytes
		for (int n = 0; n < 240;) begin
			if (n >= 90 && n < 170) begin in_noidle = 1; out_noidle = 1; end
			else begin in_noidle = 0; out_noidle = 0; end
			if ($urandom_range(9) < 2) begin
				pending_src.push_back('{stt_pkg::CMD_BYTE, 8'($urandom_range(255))});
				n++;
			end else if ($urandom_range(39) == 0) begin
				add_end();
				n++;
			end else begin
				frag = rand_fragment();
				add_text(frag);
				n += frag.len();
			end
			if ($urandom_range(4) == 0) add_text(" ");
			while (pending_src.size() > 8) @(posedge clk);
			if (n % 100 < 3) begin
				src_pause = 1;
				while (in_valid || expected_tokens.size() > 0) @(posedge clk);
				src_pause = 0;
			end
		end
		add_end();
		wait_drained();
		stim_done = 1;
	end

	initial begin
		wait (stim_done);
		repeat (10) @(posedge clk);
		if (errors == 0) $display("tb_top passed");
		else $display("tb_top failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("tb_top failed");
		$finish;
	end
endmodule
`default_nettype wire
